FILE: rtl/core/walt_pkg.sv
// Shared types, codes and constants of the write-ahead log tracker.
`timescale 1ns / 1ps

package walt_pkg;

  localparam int LOG_ENTRIES_DEF   = 30;
  localparam int MAX_OP_BLOCKS_DEF = 10;

  // Counts, header count and slot index are 5 bits wide on the ports.
  localparam int CNT_W      = 5;
  localparam int BLK_W      = 32;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int KIND_W     = 2;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam int LOG_BLK_W  = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_LOG_START  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_LOG_BLOCKS = CFG_ADDR_W'(1);

  localparam logic [BLK_W-1:0]     LOG_START_RST  = BLK_W'(2);
  localparam logic [LOG_BLK_W-1:0] LOG_BLOCKS_RST = LOG_BLK_W'(30);

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_END    = 2'd1,
    CMD_RECORD = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_WAIT     = 3'd1,
    STAT_TOO_BIG  = 3'd2,
    STAT_OUTSIDE  = 3'd3,
    STAT_NO_BEGIN = 3'd4
  } status_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 2'd0,
    KIND_COPY   = 2'd1,
    KIND_HEADER = 2'd2
  } op_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COPY_LOG,
    S_HDR,
    S_COPY_HOME,
    S_CLEAR
  } state_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KIND_W-1:0]   op_kind;
    logic [BLK_W-1:0]    src_block;
    logic [BLK_W-1:0]    dst_block;
    logic [CNT_W-1:0]    header_count;
    logic [CNT_W-1:0]    entry_index;
    logic                last;
  } res_t;

endpackage

FILE: rtl/core/walt_if.sv
// Channel interfaces: command beats, result beats and register writes.
`timescale 1ns / 1ps

interface walt_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [walt_pkg::CMD_W-1:0]   cmd;
  logic [walt_pkg::BLK_W-1:0]   block_no;

  modport source (output valid, output cmd, output block_no, input ready);
  modport sink   (input valid, input cmd, input block_no, output ready);
endinterface

interface walt_res_if;
  logic                          valid;
  logic                          ready;
  logic [walt_pkg::STATUS_W-1:0] status;
  logic [walt_pkg::KIND_W-1:0]   op_kind;
  logic [walt_pkg::BLK_W-1:0]    src_block;
  logic [walt_pkg::BLK_W-1:0]    dst_block;
  logic [walt_pkg::CNT_W-1:0]    header_count;
  logic [walt_pkg::CNT_W-1:0]    entry_index;
  logic                          last;

  modport source (output valid, output status, output op_kind, output src_block,
                  output dst_block, output header_count, output entry_index,
                  output last, input ready);
  modport sink   (input valid, input status, input op_kind, input src_block,
                  input dst_block, input header_count, input entry_index,
                  input last, output ready);
endinterface

interface walt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [walt_pkg::CFG_ADDR_W-1:0] addr;
  logic [walt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: rtl/core/walt_ram.sv
// Entry table: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module walt_ram #(
  parameter int DEPTH = walt_pkg::LOG_ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [walt_pkg::BLK_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [walt_pkg::BLK_W-1:0] rdata_o
);

  logic [walt_pkg::BLK_W-1:0] mem [DEPTH];
  logic [walt_pkg::BLK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/write_ahead_log_tracker.sv
// Top level of the group-commit redo log tracker.
//
//   channel  dir  beat                               ready
//   in_ch    in   cmd, block_no                      idle and result slot free
//   out_ch   out  status .. last, one per result     from downstream
//   cfg_ch   in   addr, data                         always high
//
// Begin, end without commit and unknown commands: one result beat each.
// Record: after the accept, one table compare per cycle over the logged entries
// (none when the table is empty), cut short by a hit.
// A committing end emits 2*entry_count+2 beats at one per cycle after its accept
// cycle, paced by the single table read port; output stalls just hold the walk.
// Reset clears counts, state and flags; the table and payload are not cleared.
`timescale 1ns / 1ps

module write_ahead_log_tracker #(
  parameter int LOG_ENTRIES   = walt_pkg::LOG_ENTRIES_DEF,
  parameter int MAX_OP_BLOCKS = walt_pkg::MAX_OP_BLOCKS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  walt_cmd_if.sink   in_ch,
  walt_res_if.source out_ch,
  walt_cfg_if.sink   cfg_ch
);

  localparam int AW     = $clog2(LOG_ENTRIES);
  localparam int CW     = walt_pkg::CNT_W;
  localparam int NEED_W = CW + 2 + $clog2(MAX_OP_BLOCKS + 1);

  walt_pkg::state_e state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    outs_q, outs_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [walt_pkg::BLK_W-1:0] blk_q, blk_d;
  logic [walt_pkg::BLK_W-1:0] log_start_q;
  logic [walt_pkg::LOG_BLK_W-1:0] log_blocks_q;
  walt_pkg::res_t   res_q, res_d;
  logic             res_vld_q, res_vld_d;

  logic             out_free;
  logic             in_acc;
  logic             emit;
  logic [NEED_W-1:0] need;
  logic             full;
  logic             hit;
  logic             more;
  logic [walt_pkg::BLK_W-1:0] slot_blk;

  logic             ram_we;
  logic             ram_re;
  logic [CW-1:0]    ram_raddr;
  logic [walt_pkg::BLK_W-1:0] ram_rdata;

  walt_ram #(
    .DEPTH(LOG_ENTRIES),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(blk_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign out_free     = !res_vld_q || out_ch.ready;
  assign in_ch.ready  = (state_q == walt_pkg::S_IDLE) && out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign need = NEED_W'(cnt_q)
              + (NEED_W'(outs_q) + NEED_W'(1)) * NEED_W'(MAX_OP_BLOCKS);
  assign full = (cnt_q >= CW'(LOG_ENTRIES))
             || ((17'(cnt_q) + 17'd1) >= 17'(log_blocks_q));
  assign hit  = cmp_vld_q && (ram_rdata == blk_q);
  assign more = (6'(idx_q) + 6'd1) < 6'(cnt_q);
  assign slot_blk = log_start_q + walt_pkg::BLK_W'(idx_q) + walt_pkg::BLK_W'(1);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    outs_d    = outs_q;
    idx_d     = idx_q;
    cmp_vld_d = cmp_vld_q;
    blk_d     = blk_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    emit      = 1'b0;
    res_d     = '0;
    res_d.status  = walt_pkg::STAT_OK;
    res_d.op_kind = walt_pkg::KIND_NONE;

    case (state_q)
      walt_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_ch.cmd)
            walt_pkg::CMD_BEGIN: begin
              emit       = 1'b1;
              res_d.last = 1'b1;
              if (need > NEED_W'(LOG_ENTRIES)) begin
                res_d.status = walt_pkg::STAT_WAIT;
              end else begin
                outs_d = outs_q + CW'(1);
              end
            end
            walt_pkg::CMD_RECORD: begin
              if (full) begin
                emit         = 1'b1;
                res_d.last   = 1'b1;
                res_d.status = walt_pkg::STAT_TOO_BIG;
              end else if (outs_q == '0) begin
                emit         = 1'b1;
                res_d.last   = 1'b1;
                res_d.status = walt_pkg::STAT_OUTSIDE;
              end else begin
                blk_d   = in_ch.block_no;
                state_d = walt_pkg::S_SEARCH;
                if (cnt_q != '0) begin
                  ram_re    = 1'b1;
                  idx_d     = CW'(1);
                  cmp_vld_d = 1'b1;
                end else begin
                  idx_d     = '0;
                  cmp_vld_d = 1'b0;
                end
              end
            end
            walt_pkg::CMD_END: begin
              if (outs_q == '0) begin
                emit         = 1'b1;
                res_d.last   = 1'b1;
                res_d.status = walt_pkg::STAT_NO_BEGIN;
              end else begin
                outs_d = outs_q - CW'(1);
                if (outs_q != CW'(1) || cnt_q == '0) begin
                  emit       = 1'b1;
                  res_d.last = 1'b1;
                end else begin
                  // last op closed with entries logged: start the commit
                  ram_re  = 1'b1;
                  idx_d   = '0;
                  state_d = walt_pkg::S_COPY_LOG;
                end
              end
            end
            default: begin
              emit       = 1'b1;
              res_d.last = 1'b1;
            end
          endcase
        end
      end

      walt_pkg::S_SEARCH: begin
        // idx_q is the next slot to read; the compared slot is idx_q-1
        if (hit) begin
          if (out_free) begin
            emit              = 1'b1;
            res_d.last        = 1'b1;
            res_d.entry_index = idx_q - CW'(1);
            state_d           = walt_pkg::S_IDLE;
          end
        end else if (idx_q == cnt_q) begin
          if (out_free) begin
            ram_we            = 1'b1;
            emit              = 1'b1;
            res_d.last        = 1'b1;
            res_d.entry_index = cnt_q;
            cnt_d             = cnt_q + CW'(1);
            state_d           = walt_pkg::S_IDLE;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q;
          idx_d     = idx_q + CW'(1);
          cmp_vld_d = 1'b1;
        end
      end

      walt_pkg::S_COPY_LOG: begin
        if (out_free) begin
          emit            = 1'b1;
          res_d.op_kind   = walt_pkg::KIND_COPY;
          res_d.src_block = ram_rdata;
          res_d.dst_block = slot_blk;
          if (more) begin
            ram_re    = 1'b1;
            ram_raddr = idx_q + CW'(1);
            idx_d     = idx_q + CW'(1);
          end else begin
            state_d = walt_pkg::S_HDR;
          end
        end
      end

      walt_pkg::S_HDR: begin
        if (out_free) begin
          emit               = 1'b1;
          res_d.op_kind      = walt_pkg::KIND_HEADER;
          res_d.dst_block    = log_start_q;
          res_d.header_count = cnt_q;
          ram_re             = 1'b1;
          idx_d              = '0;
          state_d            = walt_pkg::S_COPY_HOME;
        end
      end

      walt_pkg::S_COPY_HOME: begin
        if (out_free) begin
          emit            = 1'b1;
          res_d.op_kind   = walt_pkg::KIND_COPY;
          res_d.src_block = slot_blk;
          res_d.dst_block = ram_rdata;
          if (more) begin
            ram_re    = 1'b1;
            ram_raddr = idx_q + CW'(1);
            idx_d     = idx_q + CW'(1);
          end else begin
            state_d = walt_pkg::S_CLEAR;
          end
        end
      end

      walt_pkg::S_CLEAR: begin
        if (out_free) begin
          emit            = 1'b1;
          res_d.op_kind   = walt_pkg::KIND_HEADER;
          res_d.dst_block = log_start_q;
          res_d.last      = 1'b1;
          cnt_d           = '0;
          state_d         = walt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = walt_pkg::S_IDLE;
      end
    endcase

    if (!emit) begin
      res_d = res_q;
    end
    res_vld_d = emit ? 1'b1 : (out_ch.ready ? 1'b0 : res_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= walt_pkg::S_IDLE;
      cnt_q        <= '0;
      outs_q       <= '0;
      idx_q        <= '0;
      cmp_vld_q    <= 1'b0;
      res_vld_q    <= 1'b0;
      log_start_q  <= walt_pkg::LOG_START_RST;
      log_blocks_q <= walt_pkg::LOG_BLOCKS_RST;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      outs_q    <= outs_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      res_vld_q <= res_vld_d;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          walt_pkg::CFG_LOG_START:  log_start_q  <= cfg_ch.data;
          walt_pkg::CFG_LOG_BLOCKS: log_blocks_q <= cfg_ch.data[walt_pkg::LOG_BLK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    res_q <= res_d;
  end

  assign out_ch.valid        = res_vld_q;
  assign out_ch.status       = res_q.status;
  assign out_ch.op_kind      = res_q.op_kind;
  assign out_ch.src_block    = res_q.src_block;
  assign out_ch.dst_block    = res_q.dst_block;
  assign out_ch.header_count = res_q.header_count;
  assign out_ch.entry_index  = res_q.entry_index;
  assign out_ch.last         = res_q.last;

endmodule
